>>> hw/rtl/tg3d_pkg.sv
// Shared constants, types and helpers of the tangent-to-3D-vector pipeline.
package tg3d_pkg;

    // fixed-point format of points and basis vectors
    localparam int F_BITS = 14;
    localparam int ONE    = 1 << F_BITS;

    // item field widths
    localparam int W_X = 16;              // point component
    localparam int W_A = 16;              // tangent coordinate, Q4.12
    localparam int W_C = W_X + 1;         // x0 + b*x1
    localparam int W_M = W_C + W_X - F_BITS;
    localparam int W_V = ((W_M > F_BITS + 2) ? W_M : F_BITS + 2) + 1;
    localparam int W_SQ = 2 * W_V;        // squared norm
    localparam int W_R  = W_V;            // norm
    localparam int W_DR = W_V + F_BITS;   // divider remainder
    localparam int Q_W  = F_BITS + 1;     // quotient magnitude, up to ONE
    localparam int W_U  = F_BITS + 2;     // signed unit component

    // stage counts of the shared units
    localparam int L_VN  = 2 + W_R;
    localparam int L_DIV = Q_W + 2;

    // configuration register indexes
    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] CFG_POLE  = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_DEGEN = 1'b1;
    localparam int W_CFG = 15;

    typedef logic [2:0][W_V-1:0] t_vec;
    typedef logic [2:0][W_U-1:0] t_uvec;

    // divider result: unit vector and zero-norm status
    typedef struct packed {
        t_uvec unit;
        logic  zero;
    } t_div_res;

    // magnitude of a two's complement component
    function automatic logic [W_V-1:0] mag_v(input logic [W_V-1:0] v);
        return v[W_V-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

>>> hw/rtl/tg3d_vnorm.sv
// Pipelined vector norm: squares, sum and a one-bit-per-stage square root.
module tg3d_vnorm (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  tg3d_pkg::t_vec           i_vec,
    output tg3d_pkg::t_vec           o_vec,
    output logic [tg3d_pkg::W_R-1:0] o_nrm
);
    import tg3d_pkg::*;

    logic [W_SQ-1:0] r_sq   [3];
    logic [W_SQ-1:0] r_rem  [W_R+1];
    logic [W_R-1:0]  r_root [W_R+1];
    logic [W_SQ-1:0] n_rem  [W_R];
    logic [W_R-1:0]  n_root [W_R];
    logic [W_SQ:0]   w_dlt  [W_R];
    t_vec            r_vd   [L_VN];

    // one root bit per stage, MSB first; remainder holds s - root^2
    always_comb begin
        for (int j = 0; j < W_R; j++) begin
            w_dlt[j] = ((W_SQ+1)'(r_root[j]) << (W_R - j))
                     + ((W_SQ+1)'(1) << (2 * (W_R - 1 - j)));
            if ({1'b0, r_rem[j]} >= w_dlt[j]) begin
                n_rem[j]  = r_rem[j] - w_dlt[j][W_SQ-1:0];
                n_root[j] = r_root[j] | (W_R'(1) << (W_R - 1 - j));
            end else begin
                n_rem[j]  = r_rem[j];
                n_root[j] = r_root[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_sq[c] <= W_SQ'(mag_v(i_vec[c])) * W_SQ'(mag_v(i_vec[c]));
            end
            r_rem[0]  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_root[0] <= '0;
            for (int j = 0; j < W_R; j++) begin
                r_rem[j+1]  <= n_rem[j];
                r_root[j+1] <= n_root[j];
            end
        end
    end

    // vector travels alongside the norm
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vd[0] <= i_vec;
            for (int k = 1; k < L_VN; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
        end
    end

    assign o_vec = r_vd[L_VN-1];
    assign o_nrm = r_root[W_R];

endmodule

>>> hw/rtl/tg3d_vdiv.sv
// Pipelined normalizer: three restoring dividers, one quotient bit per stage.
module tg3d_vdiv (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  tg3d_pkg::t_vec           i_vec,
    input  logic [tg3d_pkg::W_R-1:0] i_nrm,
    output tg3d_pkg::t_div_res       o_res
);
    import tg3d_pkg::*;

    logic [W_DR-1:0] r_rem  [Q_W+1][3];
    logic [Q_W-1:0]  r_q    [Q_W+1][3];
    logic [W_R-1:0]  r_nrm  [Q_W+1];
    logic [2:0]      r_neg  [Q_W+1];
    logic            r_zero [Q_W+1];
    logic [W_DR-1:0] n_rem  [Q_W][3];
    logic [Q_W-1:0]  n_q    [Q_W][3];
    logic [W_DR-1:0] w_dvs  [Q_W];
    logic [W_U-1:0]  w_qs   [3];
    t_div_res        r_res;

    // compare-subtract of the shifted norm, quotient MSB first
    always_comb begin
        for (int j = 0; j < Q_W; j++) begin
            w_dvs[j] = W_DR'(r_nrm[j]) << (F_BITS - j);
            for (int c = 0; c < 3; c++) begin
                if (r_rem[j][c] >= w_dvs[j]) begin
                    n_rem[j][c] = r_rem[j][c] - w_dvs[j];
                    n_q[j][c]   = r_q[j][c] | (Q_W'(1) << (F_BITS - j));
                end else begin
                    n_rem[j][c] = r_rem[j][c];
                    n_q[j][c]   = r_q[j][c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_rem[0][c] <= W_DR'(mag_v(i_vec[c])) << F_BITS;
                r_q[0][c]   <= '0;
                r_neg[0][c] <= i_vec[c][W_V-1];
            end
            r_nrm[0]  <= i_nrm;
            r_zero[0] <= (i_nrm == '0);
            for (int j = 0; j < Q_W; j++) begin
                r_rem[j+1]  <= n_rem[j];
                r_q[j+1]    <= n_q[j];
                r_nrm[j+1]  <= r_nrm[j];
                r_neg[j+1]  <= r_neg[j];
                r_zero[j+1] <= r_zero[j];
            end
        end
    end

    // restore sign; zero norm gives a zero vector
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_qs[c] = {1'b0, r_q[Q_W][c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                if (r_zero[Q_W]) begin
                    r_res.unit[c] <= '0;
                end else if (r_neg[Q_W][c]) begin
                    r_res.unit[c] <= ~w_qs[c] + 1'b1;
                end else begin
                    r_res.unit[c] <= w_qs[c];
                end
            end
            r_res.zero <= r_zero[Q_W];
        end
    end

    assign o_res = r_res;

endmodule

>>> hw/rtl/tangent_to_3d_vector_unit.sv
// Top level: tangent-plane basis and 3D tangent vector pipeline.
//
// Input stream (s_axis): one request holds a point on the unit sphere (Q2.14)
// and two tangent coordinates (Q4.12). Output stream (m_axis): the 3D tangent
// vector (Q4.12, saturated) in tdata and in tuser a flag for clipping or a zero norm.
// Every request yields exactly one result, in order.
// Throughput: one request per cycle while the sink keeps up. The depth is set
// by two rounds of norm plus normalize: each norm is a 20-stage square root,
// each normalize a 15-stage restoring divider, the two third-axis candidates
// run side by side.
// Configuration: i_cfg_we writes register i_cfg_idx (0 pole threshold,
// 1 degenerate threshold) at the clock edge; write only while idle.
// Reset (synchronous, active low) empties the pipeline and sets both
// thresholds to 1; s_axis_tready is low during reset.
// Stall: when a result waits and m_axis_tready is low the whole pipeline
// holds and s_axis_tready drops; nothing is lost or repeated.
module tangent_to_3d_vector_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // point_x, point_y, point_z, tangent_first, tangent_second
    input  logic [79:0]                     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // vec_x, vec_y, vec_z
    output logic [47:0]                     m_axis_tdata,
    // saturated, or a zero norm in either normalize
    output logic                            m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [tg3d_pkg::CFG_IW-1:0]     i_cfg_idx,
    input  logic [tg3d_pkg::W_CFG-1:0]      i_cfg_data
);
    import tg3d_pkg::*;

    localparam int L_A = L_VN + L_DIV;
    localparam int W_P = W_X + W_U;
    localparam int W_S = W_P - F_BITS + 1;
    localparam logic signed [W_V-1:0] ONE_V   = W_V'(ONE);
    localparam logic signed [W_S-1:0] VEC_MAX = W_S'(32767);
    localparam logic signed [W_S-1:0] VEC_MIN = -W_S'(32768);

    typedef struct packed {
        logic [2:0][W_X-1:0] x;
        logic [W_A-1:0]      a1;
        logic [W_A-1:0]      a2;
    } t_side_a;

    typedef struct packed {
        logic [W_A-1:0] a1;
        logic [W_A-1:0] a2;
        t_uvec          u2;
        logic           zero;
    } t_side_b;

    logic en;

    // configuration registers
    logic [W_CFG-1:0] r_pole_thr, r_degen_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_thr  <= W_CFG'(1);
            r_degen_thr <= W_CFG'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POLE:  r_pole_thr  <= i_cfg_data;
                CFG_DEGEN: r_degen_thr <= i_cfg_data;
            endcase
        end
    end

    // the whole pipeline moves when the output slot is free or being taken
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = i_rst_n && en;

    // valid bits
    logic             r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v;
    logic [L_A-1:0]   r_va;
    logic [L_VN-1:0]  r_vb1;
    logic [L_DIV-1:0] r_vb2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r_va  <= '0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r_vb1 <= '0;
            r6_v  <= 1'b0;
            r_vb2 <= '0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
        end else if (en) begin
            r1_v  <= s_axis_tvalid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r_va  <= {r_va[L_A-2:0], r3_v};
            r4_v  <= r_va[L_A-1];
            r5_v  <= r4_v;
            r_vb1 <= {r_vb1[L_VN-2:0], r5_v};
            r6_v  <= r_vb1[L_VN-1];
            r_vb2 <= {r_vb2[L_DIV-2:0], r6_v};
            r7_v  <= r_vb2[L_DIV-1];
            r8_v  <= r7_v;
        end
    end

    // stage 1: pole test and first reference vector
    logic signed [W_X-1:0] w_in_x [3];
    logic signed [W_X+1:0] w_dx0;
    logic [W_X+1:0]        w_ad0, w_ad1, w_ad2;
    logic [W_X+2:0]        w_dist;
    logic                  w_b;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_in_x[i] = s_axis_tdata[i*W_X +: W_X];
        end
        w_dx0  = (W_X+2)'(w_in_x[0]) - (W_X+2)'(ONE);
        w_ad0  = w_dx0[W_X+1] ? (~w_dx0 + 1'b1) : w_dx0;
        w_ad1  = w_in_x[1][W_X-1] ? (~(W_X+2)'(w_in_x[1]) + 1'b1) : (W_X+2)'(w_in_x[1]);
        w_ad2  = w_in_x[2][W_X-1] ? (~(W_X+2)'(w_in_x[2]) + 1'b1) : (W_X+2)'(w_in_x[2]);
        w_dist = (W_X+3)'(w_ad0) + (W_X+3)'(w_ad1) + (W_X+3)'(w_ad2);
        w_b    = w_dist < (W_X+3)'(r_pole_thr);
    end

    logic signed [W_X-1:0] r1_x [3];
    logic [W_A-1:0]        r1_a1, r1_a2;
    logic signed [W_C-1:0] r1_c;
    logic                  r1_b;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) r1_x[i] <= w_in_x[i];
            r1_a1 <= s_axis_tdata[3*W_X +: W_A];
            r1_a2 <= s_axis_tdata[3*W_X+W_A +: W_A];
            r1_c  <= W_C'(w_in_x[0]) + (w_b ? W_C'(w_in_x[1]) : W_C'(0));
            r1_b  <= w_b;
        end
    end

    // stage 2: c * x products
    logic signed [W_C+W_X-1:0] w_cx [3];
    logic signed [W_V-1:0]     r2_m [3];
    logic signed [W_X-1:0]     r2_x [3];
    logic [W_A-1:0]            r2_a1, r2_a2;
    logic                      r2_b;

    always_comb begin
        for (int i = 0; i < 3; i++) w_cx[i] = r1_c * r1_x[i];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_m[i] <= W_V'(w_cx[i] >>> F_BITS);
                r2_x[i] <= r1_x[i];
            end
            r2_a1 <= r1_a1;
            r2_a2 <= r1_a2;
            r2_b  <= r1_b;
        end
    end

    // stage 3: projected first basis vector
    t_vec    r3_u2p;
    t_side_a r3_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_u2p[0] <= ONE_V - r2_m[0];
            r3_u2p[1] <= (r2_b ? ONE_V : W_V'(0)) - r2_m[1];
            r3_u2p[2] <= -r2_m[2];
            for (int i = 0; i < 3; i++) r3_side.x[i] <= r2_x[i];
            r3_side.a1 <= r2_a1;
            r3_side.a2 <= r2_a2;
        end
    end

    // first basis vector: norm then normalize
    t_vec           w_u2p_d;
    logic [W_R-1:0] w_nrm_a;
    t_div_res       w_da;

    tg3d_vnorm u_norm_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vec (r3_u2p),
        .o_vec (w_u2p_d),
        .o_nrm (w_nrm_a)
    );

    tg3d_vdiv u_div_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vec (w_u2p_d),
        .i_nrm (w_nrm_a),
        .o_res (w_da)
    );

    t_side_a r_sa [L_A];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa[0] <= r3_side;
            for (int k = 1; k < L_A; k++) r_sa[k] <= r_sa[k-1];
        end
    end

    // stage 4: products for the third-axis candidates
    logic signed [W_X-1:0]   w_x [3];
    logic signed [W_U-1:0]   w_u [3];
    logic signed [2*W_X-1:0] w_xx [5];
    logic signed [2*W_U-1:0] w_uu [5];
    logic signed [W_V-1:0]   r4_px [5];
    logic signed [W_V-1:0]   r4_pu [5];
    t_side_b                 r4_side;

    // pair order: (2,0) (1,2) (2,2) (1,0) (1,1)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_x[i] = r_sa[L_A-1].x[i];
            w_u[i] = w_da.unit[i];
        end
        w_xx[0] = w_x[2] * w_x[0];
        w_xx[1] = w_x[1] * w_x[2];
        w_xx[2] = w_x[2] * w_x[2];
        w_xx[3] = w_x[1] * w_x[0];
        w_xx[4] = w_x[1] * w_x[1];
        w_uu[0] = w_u[2] * w_u[0];
        w_uu[1] = w_u[1] * w_u[2];
        w_uu[2] = w_u[2] * w_u[2];
        w_uu[3] = w_u[1] * w_u[0];
        w_uu[4] = w_u[1] * w_u[1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 5; k++) begin
                r4_px[k] <= W_V'(w_xx[k] >>> F_BITS);
                r4_pu[k] <= W_V'(w_uu[k] >>> F_BITS);
            end
            r4_side.a1   <= r_sa[L_A-1].a1;
            r4_side.a2   <= r_sa[L_A-1].a2;
            r4_side.u2   <= w_da.unit;
            r4_side.zero <= w_da.zero;
        end
    end

    // stage 5: candidates from e3 and from e2
    t_vec    r5_p, r5_f;
    t_side_b r5_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_p[0] <= -r4_px[0] - r4_pu[0];
            r5_p[1] <= -r4_px[1] - r4_pu[1];
            r5_p[2] <= ONE_V - r4_px[2] - r4_pu[2];
            r5_f[0] <= -r4_px[3] - r4_pu[3];
            r5_f[1] <= ONE_V - r4_px[4] - r4_pu[4];
            r5_f[2] <= -r4_px[1] - r4_pu[1];
            r5_side <= r4_side;
        end
    end

    t_vec           w_p_d, w_f_d;
    logic [W_R-1:0] w_nrm_p, w_nrm_f;

    tg3d_vnorm u_norm_p (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vec (r5_p),
        .o_vec (w_p_d),
        .o_nrm (w_nrm_p)
    );

    tg3d_vnorm u_norm_f (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vec (r5_f),
        .o_vec (w_f_d),
        .o_nrm (w_nrm_f)
    );

    t_side_b r_sb1 [L_VN];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb1[0] <= r5_side;
            for (int k = 1; k < L_VN; k++) r_sb1[k] <= r_sb1[k-1];
        end
    end

    // stage 6: fall back to the e2 candidate when the e3 one is degenerate
    t_vec           r6_vec;
    logic [W_R-1:0] r6_nrm;
    t_side_b        r6_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (w_nrm_p < W_R'(r_degen_thr)) begin
                r6_vec <= w_f_d;
                r6_nrm <= w_nrm_f;
            end else begin
                r6_vec <= w_p_d;
                r6_nrm <= w_nrm_p;
            end
            r6_side <= r_sb1[L_VN-1];
        end
    end

    t_div_res w_dc;

    tg3d_vdiv u_div_c (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vec (r6_vec),
        .i_nrm (r6_nrm),
        .o_res (w_dc)
    );

    t_side_b r_sb2 [L_DIV];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb2[0] <= r6_side;
            for (int k = 1; k < L_DIV; k++) r_sb2[k] <= r_sb2[k-1];
        end
    end

    // stage 7: coordinate times basis products
    logic signed [W_A-1:0] w_a1, w_a2;
    logic signed [W_U-1:0] w_b2 [3];
    logic signed [W_U-1:0] w_b3 [3];
    logic signed [W_P-1:0] w_p1 [3];
    logic signed [W_P-1:0] w_p2 [3];
    logic signed [W_P-1:0] r7_p1 [3];
    logic signed [W_P-1:0] r7_p2 [3];
    logic                  r7_flag;

    always_comb begin
        w_a1 = r_sb2[L_DIV-1].a1;
        w_a2 = r_sb2[L_DIV-1].a2;
        for (int i = 0; i < 3; i++) begin
            w_b2[i] = r_sb2[L_DIV-1].u2[i];
            w_b3[i] = w_dc.unit[i];
            w_p1[i] = w_a1 * w_b2[i];
            w_p2[i] = w_a2 * w_b3[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r7_p1[i] <= w_p1[i];
                r7_p2[i] <= w_p2[i];
            end
            r7_flag <= r_sb2[L_DIV-1].zero | w_dc.zero;
        end
    end

    // stage 8: sum, scale, clamp into the output register
    logic signed [W_P:0]   w_sum [3];
    logic signed [W_S-1:0] w_sh  [3];
    logic [2:0][15:0]      r8_vec;
    logic                  r8_sat;
    logic [2:0]            w_clip;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i]  = (W_P+1)'(r7_p1[i]) + (W_P+1)'(r7_p2[i]);
            w_sh[i]   = W_S'(w_sum[i] >>> F_BITS);
            w_clip[i] = (w_sh[i] > VEC_MAX) || (w_sh[i] < VEC_MIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_sh[i] > VEC_MAX) begin
                    r8_vec[i] <= 16'h7fff;
                end else if (w_sh[i] < VEC_MIN) begin
                    r8_vec[i] <= 16'h8000;
                end else begin
                    r8_vec[i] <= w_sh[i][15:0];
                end
            end
            r8_sat <= r7_flag | (|w_clip);
        end
    end

    assign m_axis_tvalid = r8_v;
    assign m_axis_tdata  = r8_vec;
    assign m_axis_tuser  = r8_sat;

endmodule

>>> hw/rtl/tg3d_checker.sv
// Port-level checks of the tangent-to-3D-vector unit, bound to its top level.
module tg3d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // input side opens exactly when the output slot can move
    a_ready_follows_output: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready)
    ) else $error("input ready does not track output slot");

    // a stalled result holds
    a_stall_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
    ) else $error("stalled result changed");

    // reset empties the pipeline
    a_reset_clears: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && (!i_rst_n || s_axis_tready)
    ) else $error("pipeline not empty after reset");

endmodule

bind tangent_to_3d_vector_unit tg3d_checker u_tg3d_checker (.*);

>>> tb/sv/tangent_to_3d_vector_unit_chk.sv
// Checker for the tangent-to-3D-vector unit: predicts each result and compares.
`timescale 1ns / 100ps
module tangent_to_3d_vector_unit_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [79:0]                   s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [47:0]                   m_axis_tdata,
    input  logic                          m_axis_tuser,
    input  logic                          i_cfg_we,
    input  logic [tg3d_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [tg3d_pkg::W_CFG-1:0]    i_cfg_data,
    output int                            o_fail_cnt,
    output int                            o_pending
);
    import tg3d_pkg::*;

    typedef struct packed {
        logic [15:0] vz;
        logic [15:0] vy;
        logic [15:0] vx;
        logic        sat;
    } t_vec_res;

    longint    pole_thr;
    longint    degen_thr;
    t_vec_res  vec_q[$];

    function automatic longint fl_shr(longint v);
        if (v >= 0) return v >>> F_BITS;
        return -((-(v + 1)) >>> F_BITS) - 1;
    endfunction

    function automatic longint fmul(longint a, longint b);
        return fl_shr(a * b);
    endfunction

    function automatic longint iabs(longint v);
        return v < 0 ? -v : v;
    endfunction

    // floor square root of a sum of squares
    function automatic longint vnorm(longint a, longint b, longint c);
        longint s;
        longint r;
        s = a * a + b * b + c * c;
        r = longint'($sqrt(real'(s)));
        while (r * r > s) r--;
        while ((r + 1) * (r + 1) <= s) r++;
        return r;
    endfunction

    function automatic t_vec_res predict_vec(logic [79:0] d);
        longint x0, x1, x2, a1, a2, b, c, n, l1_dist, r;
        longint p[3];
        longint u2[3];
        longint q[3];
        longint u3[3];
        logic   sat;
        t_vec_res res;
        x0 = longint'($signed(d[15:0]));
        x1 = longint'($signed(d[31:16]));
        x2 = longint'($signed(d[47:32]));
        a1 = longint'($signed(d[63:48]));
        a2 = longint'($signed(d[79:64]));
        sat = 1'b0;
        // reference axis: e1, or e1+e2 near the pole
        l1_dist = iabs(x0 - ONE) + iabs(x1) + iabs(x2);
        b = (l1_dist < pole_thr) ? 1 : 0;
        c = x0 + b * x1;
        p[0] = ONE - fmul(c, x0);
        p[1] = b * ONE - fmul(c, x1);
        p[2] = -fmul(c, x2);
        n = vnorm(p[0], p[1], p[2]);
        if (n == 0) sat = 1'b1;
        for (int i = 0; i < 3; i++) u2[i] = (n == 0) ? 0 : (p[i] * ONE) / n;
        // second axis from e3, e2 when degenerate
        q[0] = -fmul(x2, x0) - fmul(u2[2], u2[0]);
        q[1] = -fmul(x2, x1) - fmul(u2[2], u2[1]);
        q[2] = ONE - fmul(x2, x2) - fmul(u2[2], u2[2]);
        n = vnorm(q[0], q[1], q[2]);
        if (n < degen_thr) begin
            q[0] = -fmul(x1, x0) - fmul(u2[1], u2[0]);
            q[1] = ONE - fmul(x1, x1) - fmul(u2[1], u2[1]);
            q[2] = -fmul(x1, x2) - fmul(u2[1], u2[2]);
            n = vnorm(q[0], q[1], q[2]);
        end
        if (n == 0) sat = 1'b1;
        for (int i = 0; i < 3; i++) u3[i] = (n == 0) ? 0 : (q[i] * ONE) / n;
        for (int i = 0; i < 3; i++) begin
            r = fl_shr(a1 * u2[i] + a2 * u3[i]);
            if (r > 32767) begin
                r = 32767;
                sat = 1'b1;
            end else if (r < -32768) begin
                r = -32768;
                sat = 1'b1;
            end
            if (i == 0) res.vx = r[15:0];
            else if (i == 1) res.vy = r[15:0];
            else res.vz = r[15:0];
        end
        res.sat = sat;
        return res;
    endfunction

    assign o_pending = vec_q.size();

    // track config, predict on request, compare on result
    always @(posedge i_clk) begin
        t_vec_res exp_r;
        if (!i_rst_n) begin
            pole_thr  <= 1;
            degen_thr <= 1;
            vec_q.delete();
            o_fail_cnt <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_POLE) pole_thr <= i_cfg_data;
                else if (i_cfg_idx == CFG_DEGEN) degen_thr <= i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                vec_q.push_back(predict_vec(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (vec_q.size() == 0) begin
                    $display("%0t: unexpected result data=%h sat=%b", $time,
                             m_axis_tdata, m_axis_tuser);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    exp_r = vec_q.pop_front();
                    if ({exp_r.vz, exp_r.vy, exp_r.vx} !== m_axis_tdata ||
                        exp_r.sat !== m_axis_tuser) begin
                        $display({"%0t: mismatch exp x=%h y=%h z=%h sat=%b",
                                  " act x=%h y=%h z=%h sat=%b"},
                                 $time, exp_r.vx, exp_r.vy, exp_r.vz, exp_r.sat,
                                 m_axis_tdata[15:0], m_axis_tdata[31:16],
                                 m_axis_tdata[47:32], m_axis_tuser);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
        end
    end
endmodule

>>> tb/sv/tangent_to_3d_vector_unit_tb.sv
// Testbench top: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps
module tangent_to_3d_vector_unit_tb;
    import tg3d_pkg::*;

    localparam int LATENCY   = 86;
    localparam int MAX_CYC   = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [79:0]       s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [47:0]       m_axis_tdata;
    logic              m_axis_tuser;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [W_CFG-1:0]  i_cfg_data;
    int                fail_cnt;
    int                pending;
    int                cyc;
    bit                hold_sink;
    bit                sink_mode;

    tangent_to_3d_vector_unit dut (.*);

    tangent_to_3d_vector_unit_chk u_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > MAX_CYC) begin
            $display("tangent_to_3d_vector_unit_tb: FAIL");
            $finish;
        end
    end

    // sink stall pattern, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_sink) m_axis_tready <= 1'b0;
        else if (sink_mode) m_axis_tready <= ($urandom_range(0, 3) != 0);
        else m_axis_tready <= 1'b1;
    end

    always begin
        repeat (200) @(negedge i_clk);
        sink_mode = ~sink_mode;
    end

    task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [W_CFG-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // one request; random gaps ahead of it when gap_max is nonzero
    task automatic send_req(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                            logic [15:0] t1, logic [15:0] t2, int gap_max);
        int gap;
        gap = (gap_max > 0 && $urandom_range(0, 4) == 0) ? $urandom_range(1, gap_max) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t2, t1, pz, py, px};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rnd_coord();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // random unit-ish point: mostly a real unit vector, sometimes near e1 or raw
    task automatic rand_req(int gap_max);
        real    a, b2, c, n;
        logic [15:0] px, py, pz;
        int     k;
        k = $urandom_range(0, 9);
        if (k < 6) begin
            a = real'($urandom_range(0, 2000)) - 1000.0;
            b2 = real'($urandom_range(0, 2000)) - 1000.0;
            c = real'($urandom_range(0, 2000)) - 1000.0;
            n = $sqrt(a * a + b2 * b2 + c * c);
            if (n < 1.0) begin a = 1.0; n = 1.0; end
            px = 16'($rtoi(a / n * 16384.0));
            py = 16'($rtoi(b2 / n * 16384.0));
            pz = 16'($rtoi(c / n * 16384.0));
        end else if (k < 8) begin
            px = 16'(16384 - $urandom_range(0, 300));
            py = 16'($signed($urandom_range(0, 200)) - 100);
            pz = 16'($signed($urandom_range(0, 200)) - 100);
        end else if (k < 9) begin
            px = rnd_coord(); py = rnd_coord(); pz = rnd_coord();
        end else begin
            px = 16'($urandom); py = 16'($urandom); pz = 16'($urandom);
        end
        send_req(px, py, pz, 16'($urandom), 16'($urandom), gap_max);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_POLE;
        i_cfg_data = '0;
        cyc = 0;
        hold_sink = 1'b0;
        sink_mode = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: poles, axes, extremes, zero norms, clipping
        send_req(16'sd16384, 0, 0, 16'sd4096, 16'sd4096, 0);
        send_req(-16'sd16384, 0, 0, 16'sh7fff, 16'sh8000, 0);
        send_req(0, 16'sd16384, 0, 16'sh8000, 16'sh8000, 0);
        send_req(0, -16'sd16384, 0, 16'sh7fff, 16'sh7fff, 0);
        send_req(0, 0, 16'sd16384, 16'sd1000, -16'sd1000, 0);
        send_req(0, 0, -16'sd16384, 16'shffff, 16'sd1, 0);
        send_req(0, 0, 0, 16'sh7fff, 16'sh7fff, 0);
        send_req(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 0);
        send_req(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 0);
        send_req(16'sd11585, 16'sd11585, 0, 16'sd4096, 16'sd4096, 0);
        send_req(16'sd11585, 0, 16'sd11585, 16'sd4096, 16'sd4096, 0);
        send_req(16'sd16383, 16'sd100, 0, 16'sh7fff, 16'sh7fff, 0);
        drain();
        cfg_write(CFG_POLE, 15'd16384);
        cfg_write(CFG_DEGEN, 15'd16384);
        send_req(16'sd16384, 0, 0, 16'sd4096, 16'sd4096, 0);
        send_req(16'sd16000, 16'sd2000, 16'sd2000, 16'sd4096, -16'sd4096, 0);
        send_req(0, 0, 16'sd16384, 16'sh7fff, 16'sh8000, 0);
        send_req(16'sd9459, 16'sd9459, 16'sd9459, 16'sd2048, 16'sd2048, 0);
        send_req(0, 16'sd16384, 0, 16'sd4096, 16'sd4096, 0);
        drain();

        // random phases over several threshold settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin cfg_write(CFG_POLE, 15'd0); cfg_write(CFG_DEGEN, 15'd0); end
                1: begin cfg_write(CFG_POLE, 15'h7fff); cfg_write(CFG_DEGEN, 15'h7fff); end
                2: begin cfg_write(CFG_POLE, 15'd1); cfg_write(CFG_DEGEN, 15'd1); end
                default: begin
                    cfg_write(CFG_POLE, 15'($urandom_range(0, 16384)));
                    cfg_write(CFG_DEGEN, 15'($urandom_range(0, 16384)));
                end
            endcase
            if (ph == 1) begin
                // long sink hold-off while requests keep coming
                hold_sink = 1'b1;
                fork
                    begin repeat (300) @(negedge i_clk); hold_sink = 1'b0; end
                    for (int i = 0; i < 90; i++) rand_req(0);
                join
            end else begin
                for (int i = 0; i < 90; i++) rand_req(ph == 3 ? 0 : 6);
            end
            drain();
        end

        if (fail_cnt == 0) begin
            $display("tangent_to_3d_vector_unit_tb: PASS");
        end else begin
            $display("tangent_to_3d_vector_unit_tb: FAIL");
        end
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/tg3d_pkg.sv
hw/rtl/tg3d_vnorm.sv
hw/rtl/tg3d_vdiv.sv
hw/rtl/tangent_to_3d_vector_unit.sv
hw/rtl/tg3d_checker.sv
tb/sv/tangent_to_3d_vector_unit_chk.sv
tb/sv/tangent_to_3d_vector_unit_tb.sv
